// ===== rtl/core/w256_pkg.sv =====
`timescale 1ns / 1ps
package w256_pkg;
	localparam int LIMB_W = 64;
	localparam int WORD_W = 256;
	localparam int HALF_W = 32;
	localparam int NHALF = 8;
	// a column holds up to eight 64-bit partial products
	localparam int COL_W = 67;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_SHL = 2'd3
	} cmd_t;

	typedef logic [WORD_W-1:0] word_t;
endpackage

// ===== rtl/core/wide_256bit_alu.sv =====
`timescale 1ns / 1ps
// every command passes the stage 1, stage 2, stage 3 and output registers before the done strobe
// throughput: one word per cycle; busy is tied low and start may be held every cycle
// the multiply uses 36 32x32 partial products in stage 1, column trees in stage 2
// and the merge of the columns in stage 3; add, subtract and shift are computed in stage 1 and travel with it
// reset clears only the valid bits; the receiver cannot stall, so results never wait
module wide_256bit_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] a_w0,
	input  logic [63:0] a_w1,
	input  logic [63:0] a_w2,
	input  logic [63:0] a_w3,
	input  logic [63:0] b_w0,
	input  logic [63:0] b_w1,
	input  logic [63:0] b_w2,
	input  logic [63:0] b_w3,
	input  logic [5:0]  shift_bytes,
	output logic        done,
	output logic [63:0] r_w0,
	output logic [63:0] r_w1,
	output logic [63:0] r_w2,
	output logic [63:0] r_w3
);
	import w256_pkg::*;

	word_t a_in, b_in;
	assign a_in = {a_w3, a_w2, a_w1, a_w0};
	assign b_in = {b_w3, b_w2, b_w1, b_w0};
	assign busy = 1'b0;

	logic acc;
	assign acc = start & ~busy;

	// stage 1: simple ops and partial products
	logic        vld_s1, mul_s1;
	word_t       res_s1;
	logic [63:0] pp_s1 [NHALF][NHALF];
	word_t       simple_c;

	always_comb begin
		simple_c = '0;
		case (cmd_t'(cmd))
			CMD_ADD: simple_c = a_in + b_in;
			CMD_SUB: simple_c = a_in - b_in;
			CMD_SHL: simple_c = shift_bytes[5] ? '0 : (a_in << {shift_bytes[4:0], 3'b000});
			default: simple_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= (cmd_t'(cmd) == CMD_MUL);
		res_s1 <= simple_c;
		for (int i = 0; i < NHALF; i++)
			for (int j = 0; j < NHALF; j++)
				if (i + j < NHALF)
					pp_s1[i][j] <= {32'd0, a_in[i*HALF_W +: HALF_W]} *
						{32'd0, b_in[j*HALF_W +: HALF_W]};
				else
					pp_s1[i][j] <= '0;
	end

	// stage 2: one balanced adder tree per column, columns 32 bits apart
	logic             vld_s2, mul_s2;
	word_t            res_s2;
	logic [COL_W-1:0] col_s2 [NHALF];
	logic [63:0]      dg_c [NHALF][NHALF];
	logic [COL_W-1:0] sum_c [NHALF];

	always_comb begin
		for (int k = 0; k < NHALF; k++)
			for (int i = 0; i < NHALF; i++)
				dg_c[k][i] = '0;
		for (int i = 0; i < NHALF; i++)
			for (int j = 0; j < NHALF; j++)
				if (i + j < NHALF)
					dg_c[i + j][i] = pp_s1[i][j];
		for (int k = 0; k < NHALF; k++)
			sum_c[k] = ((COL_W'(dg_c[k][0]) + COL_W'(dg_c[k][1])) +
				(COL_W'(dg_c[k][2]) + COL_W'(dg_c[k][3]))) +
				((COL_W'(dg_c[k][4]) + COL_W'(dg_c[k][5])) +
				(COL_W'(dg_c[k][6]) + COL_W'(dg_c[k][7])));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s2 <= mul_s1;
		res_s2 <= res_s1;
		for (int k = 0; k < NHALF; k++)
			col_s2[k] <= sum_c[k];
	end

	// stage 3: merge columns, low and carry bits of even and odd columns
	logic  vld_s3;
	word_t res_s3;
	word_t ev_lo_c, ev_hi_c, od_lo_c, od_hi_c;

	always_comb begin
		ev_lo_c = '0;
		ev_hi_c = '0;
		od_lo_c = '0;
		od_hi_c = '0;
		for (int m = 0; m < NHALF / 2; m++)
			ev_lo_c[m*LIMB_W +: LIMB_W] = col_s2[2*m][LIMB_W-1:0];
		for (int m = 0; m < NHALF / 2 - 1; m++) begin
			ev_hi_c[m*LIMB_W + LIMB_W +: COL_W-LIMB_W] = col_s2[2*m][COL_W-1:LIMB_W];
			od_lo_c[m*LIMB_W + HALF_W +: LIMB_W] = col_s2[2*m+1][LIMB_W-1:0];
			od_hi_c[m*LIMB_W + LIMB_W + HALF_W +: COL_W-LIMB_W] =
				col_s2[2*m+1][COL_W-1:LIMB_W];
		end
		// top column keeps only the bits below 2^256
		od_lo_c[WORD_W-1 -: HALF_W] = col_s2[NHALF-1][HALF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		res_s3 <= mul_s2 ? ((ev_lo_c + od_lo_c) + (ev_hi_c + od_hi_c)) : res_s2;
	end

	// output register
	logic  done_q;
	word_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= res_s3;
	end

	assign done = done_q;
	assign r_w0 = out_q[63:0];
	assign r_w1 = out_q[127:64];
	assign r_w2 = out_q[191:128];
	assign r_w3 = out_q[255:192];

	// every accepted word raises done after the stage 1, stage 2, stage 3 and output registers
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ##3 done) else $error("word lost in pipeline");
	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s3)) else $error("result without word");
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1)) else $error("stage 2 valid without stage 1");
endmodule
